/* src/dpld_pkg.sv */
package dpld_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int PROD_W       = 27;
   localparam int QUOT_W       = PROD_W - DIV100_SHIFT;

   typedef struct packed {
      logic load;
      logic check;
      logic step;
   } dpld_cmd_type;

   typedef struct packed {
      logic bad;
      logic before_end;
      logic count_full;
   } dpld_status_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] q;
      logic [YEAR_W-1:0] q100;
      logic              cent;
      prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
      q    = prod[PROD_W-1:DIV100_SHIFT];
      q100 = (YEAR_W'(q) << 6) + (YEAR_W'(q) << 5) + (YEAR_W'(q) << 2);
      cent = (q100 == y);
      return (!cent && (y[1:0] == 2'b00)) || (cent && (q[1:0] == 2'b00));
   endfunction

   // zero for a month that is not in the calendar
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
         MONTH_FEB:                                    len = leap ? 5'd29 : 5'd28;
         default:                                      len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic leap);
      logic [DAY_W-1:0] len;
      len = month_len(m, leap);
      return (len != 5'd0) && (d != 5'd0) && (d <= len);
   endfunction

endpackage

/* src/dpld_dp.sv */
module dpld_dp
   import dpld_pkg::*;
(
   input  logic                 clock,
   input  dpld_cmd_type         cmd,
   input  logic [DAY_W-1:0]     req_start_day,
   input  logic [MONTH_W-1:0]   req_start_month,
   input  logic [YEAR_W-1:0]    req_start_year,
   input  logic [DAY_W-1:0]     req_end_day,
   input  logic [MONTH_W-1:0]   req_end_month,
   input  logic [YEAR_W-1:0]    req_end_year,
   input  logic                 req_include_end,
   output dpld_status_type      status,
   output logic [COUNT_W-1:0]   rsp_day_count,
   output logic                 rsp_bad_date
);

   logic [DAY_W-1:0]   walk_day_ff,   walk_day_in;
   logic [MONTH_W-1:0] walk_month_ff, walk_month_in;
   logic [YEAR_W-1:0]  walk_year_ff,  walk_year_in;
   logic [DAY_W-1:0]   end_day_ff;
   logic [MONTH_W-1:0] end_month_ff;
   logic [YEAR_W-1:0]  end_year_ff;
   logic               inc_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               walk_leap_ff, end_leap_ff;
   logic               bad_ff;
   logic [DAY_W-1:0]   walk_len;
   logic               bad_now;

   assign walk_len = month_len(walk_month_ff, walk_leap_ff);
   assign bad_now  = !date_ok(walk_day_ff, walk_month_ff, walk_leap_ff)
                     || !date_ok(end_day_ff, end_month_ff, end_leap_ff);

   assign status.bad        = bad_now;
   assign status.count_full = (count_ff == COUNT_MAX);
   assign status.before_end = (walk_year_ff < end_year_ff)
      || ((walk_year_ff == end_year_ff) && ((walk_month_ff < end_month_ff)
      || ((walk_month_ff == end_month_ff) && (walk_day_ff < end_day_ff))));

   always_comb begin
      walk_day_in   = walk_day_ff;
      walk_month_in = walk_month_ff;
      walk_year_in  = walk_year_ff;
      count_in      = count_ff;
      if (cmd.load) begin
         walk_day_in   = req_start_day;
         walk_month_in = req_start_month;
         walk_year_in  = req_start_year;
         count_in      = '0;
      end else if (cmd.step) begin
         count_in = count_ff + COUNT_W'(1);
         if (walk_day_ff == walk_len) begin
            walk_day_in = DAY_W'(1);
            if (walk_month_ff == MONTH_DEC) begin
               walk_month_in = MONTH_JAN;
               walk_year_in  = walk_year_ff + YEAR_W'(1);
            end else begin
               walk_month_in = walk_month_ff + MONTH_W'(1);
            end
         end else begin
            walk_day_in = walk_day_ff + DAY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_day_ff   <= walk_day_in;
      walk_month_ff <= walk_month_in;
      walk_year_ff  <= walk_year_in;
      count_ff      <= count_in;
      // leap flags are registered from the year registers; a year change lands on Jan 1
      walk_leap_ff  <= is_leap(walk_year_ff);
      end_leap_ff   <= is_leap(end_year_ff);
      if (cmd.load) begin
         end_day_ff   <= req_end_day;
         end_month_ff <= req_end_month;
         end_year_ff  <= req_end_year;
         inc_ff       <= req_include_end;
      end
      if (cmd.check) begin
         bad_ff <= bad_now;
      end
   end

   always_comb begin
      if (bad_ff) begin
         rsp_day_count = '0;
      end else if (count_ff == COUNT_MAX) begin
         rsp_day_count = COUNT_MAX;
      end else begin
         rsp_day_count = count_ff + COUNT_W'(inc_ff);
      end
   end

   assign rsp_bad_date = bad_ff;

endmodule

/* src/dpld_ctrl.sv */
module dpld_ctrl
   import dpld_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  dpld_status_type status,
   output dpld_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CALC  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         // wait for the leap flags of both years
         ST_CALC: state_in = ST_CHECK;
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.bad ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (status.before_end && !status.count_full) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* src/date_period_length_days.sv */
// Sequence: the rsp_valid strobe follows the load and the date check for a bad date, and
// follows a walk of N days as well for a valid pair, N the days walked (capped at 4194303).
// Throughput: one request at a time; busy drops the cycle after the result strobe;
// one calendar day is walked per cycle.
// Reset: synchronous, active high; returns the controller to idle.
// The result is shown for one cycle only; the receiver cannot stall it.
module date_period_length_days
   import dpld_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DAY_W-1:0]     req_start_day,
   input  logic [MONTH_W-1:0]   req_start_month,
   input  logic [YEAR_W-1:0]    req_start_year,
   input  logic [DAY_W-1:0]     req_end_day,
   input  logic [MONTH_W-1:0]   req_end_month,
   input  logic [YEAR_W-1:0]    req_end_year,
   input  logic                 req_include_end,
   output logic                 rsp_valid,
   output logic [COUNT_W-1:0]   rsp_day_count,
   output logic                 rsp_bad_date
);

   dpld_cmd_type    cmd;
   dpld_status_type status;

   dpld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dpld_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_start_day   (req_start_day),
      .req_start_month (req_start_month),
      .req_start_year  (req_start_year),
      .req_end_day     (req_end_day),
      .req_end_month   (req_end_month),
      .req_end_year    (req_end_year),
      .req_include_end (req_include_end),
      .status          (status),
      .rsp_day_count   (rsp_day_count),
      .rsp_bad_date    (rsp_bad_date)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after result");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_date) |-> (rsp_day_count == '0))
      else $error("bad date with nonzero count");

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule
